// ===== sv/pwts_pkg.sv =====
`default_nettype none

package pwts_pkg;

   // item operation codes
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_PROJECT = 1'b1;

   // configuration register indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // fixed-point layout
   localparam int COEF_W    = 32;              // Q16.16 coefficient and coordinate
   localparam int PROD_W    = 64;              // full product
   localparam int FRAC_IN   = 16;              // fraction bits of Q16.16
   localparam int CLIP_W    = 50;              // exact sum of three floored products + bias
   localparam int WABS_W    = 48;              // clip w once known positive
   localparam int MAG_W     = 49;              // |clip|, clamped to 2w
   localparam int FRAC_BITS = 8;               // screen fraction bits
   localparam int MAT_DEPTH = 16;
   localparam int MAT_IDX_W = 4;

   // 0.1 in Q16.16
   localparam logic signed [CLIP_W-1:0] W_MIN = CLIP_W'(6554);

   // matrix rows used for clip x, y and w
   localparam int NUM_ROWS = 3;
   localparam int ROW_SEL [NUM_ROWS] = '{0, 1, 3};

endpackage

`default_nettype wire

// ===== sv/pwts_div.sv =====
`default_nettype none

// two-lane pipelined restoring divider, one quotient bit per stage
module pwts_div #(
   parameter int PIXEL_BITS = 13,
   parameter int TAG_W      = 3
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   en,
   input  wire logic                                   in_valid,
   input  wire logic [PIXEL_BITS+pwts_pkg::MAG_W+pwts_pkg::FRAC_BITS-2:0] in_num [2],
   input  wire logic [pwts_pkg::WABS_W-1:0]            in_den,
   input  wire logic [TAG_W-1:0]                       in_tag,
   output logic                                        out_valid,
   output logic [PIXEL_BITS+pwts_pkg::FRAC_BITS-1:0]   out_quot [2],
   output logic [TAG_W-1:0]                            out_tag
);

   localparam int NB = PIXEL_BITS + pwts_pkg::MAG_W + pwts_pkg::FRAC_BITS - 1;
   localparam int QB = PIXEL_BITS + pwts_pkg::FRAC_BITS;
   localparam int WB = pwts_pkg::WABS_W;

   logic [NB-1:0]    rem_ff  [QB][2];
   logic [NB-1:0]    rem_in  [QB][2];
   logic [QB-1:0]    quot_ff [QB][2];
   logic [QB-1:0]    quot_in [QB][2];
   logic [WB-1:0]    den_ff  [QB];
   logic [WB-1:0]    den_in  [QB];
   logic [TAG_W-1:0] tag_ff  [QB];
   logic [TAG_W-1:0] tag_in  [QB];
   logic [QB-1:0]    valid_ff;
   logic [QB-1:0]    valid_in;

   // each stage tries to subtract the divisor shifted to its quotient bit
   always_comb begin
      logic [NB-1:0] rem_prev;
      logic [QB-1:0] quot_prev;
      logic [NB:0]   trial;
      for (int k = 0; k < QB; k++) begin
         den_in[k]   = (k == 0) ? in_den   : den_ff[k-1];
         tag_in[k]   = (k == 0) ? in_tag   : tag_ff[k-1];
         valid_in[k] = (k == 0) ? in_valid : valid_ff[k-1];
         for (int l = 0; l < 2; l++) begin
            rem_prev  = (k == 0) ? in_num[l] : rem_ff[k-1][l];
            quot_prev = (k == 0) ? '0 : quot_ff[k-1][l];
            trial = {1'b0, rem_prev} - (((NB+1)'(den_in[k])) << (QB - 1 - k));
            rem_in[k][l]  = trial[NB] ? rem_prev : trial[NB-1:0];
            quot_in[k][l] = {quot_prev[QB-2:0], ~trial[NB]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         den_ff  <= den_in;
         tag_ff  <= tag_in;
      end
   end

   assign out_valid   = valid_ff[QB-1];
   assign out_quot[0] = quot_ff[QB-1][0];
   assign out_quot[1] = quot_ff[QB-1][1];
   assign out_tag     = tag_ff[QB-1];

endmodule

`default_nettype wire

// ===== sv/perspective_world_to_screen.sv =====
`default_nettype none

// channel   dir  handshake             word
// req_      in   req_valid/req_ready   operation, coef_index, coef_value, pos_x/y/z
// rsp_      out  rsp_valid/rsp_ready   visible, screen_x, screen_y
// csr_      in   csr_valid/csr_ready   csr_index, csr_data
//
// one word per cycle while rsp_ is not stalled; a project word passes through
// 5 transform/setup stages, PIXEL_BITS+8 divider stages and 1 output stage
// load words update the matrix at accept and give no result
// reset clears the matrix to zero and the viewport to 1920 x 1080
// a stall at rsp_ halts every stage at once; nothing is dropped or repeated
module perspective_world_to_screen #(
   parameter int PIXEL_BITS = 13
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_operation,
   input  wire logic [3:0]                   req_coef_index,
   input  wire logic signed [31:0]           req_coef_value,
   input  wire logic signed [31:0]           req_pos_x,
   input  wire logic signed [31:0]           req_pos_y,
   input  wire logic signed [31:0]           req_pos_z,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_visible,
   output logic [PIXEL_BITS+7:0]             rsp_screen_x,
   output logic [PIXEL_BITS+7:0]             rsp_screen_y,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic                         csr_index,
   input  wire logic [PIXEL_BITS-1:0]        csr_data
);

   localparam int CW  = pwts_pkg::COEF_W;
   localparam int PW  = pwts_pkg::PROD_W;
   localparam int FI  = pwts_pkg::FRAC_IN;
   localparam int LW  = pwts_pkg::CLIP_W;
   localparam int WB  = pwts_pkg::WABS_W;
   localparam int MB  = pwts_pkg::MAG_W;
   localparam int FB  = pwts_pkg::FRAC_BITS;
   localparam int NR  = pwts_pkg::NUM_ROWS;
   localparam int HB  = PIXEL_BITS - 1;
   localparam int NB  = HB + MB + FB;
   localparam int QB  = PIXEL_BITS + FB;
   localparam int VB  = PIXEL_BITS + FB + 1;

   logic en;
   logic accept;

   logic [PIXEL_BITS-1:0] width_ff;
   logic [PIXEL_BITS-1:0] height_ff;
   logic [HB-1:0]         half_w;
   logic [HB-1:0]         half_h;

   logic [CW-1:0] mat_ff [pwts_pkg::MAT_DEPTH];

   logic                 s1_valid_ff;
   logic signed [PW-1:0] prod_ff [NR][3];
   logic signed [CW-1:0] bias_ff [NR];
   logic signed [CW-1:0] pos [3];

   logic                 s2_valid_ff;
   logic signed [LW-1:0] clip_ff [NR];

   logic          s3_valid_ff;
   logic          s3_vis_ff;
   logic [WB-1:0] s3_w_ff;
   logic [MB-1:0] s3_mag_ff [2];
   logic [1:0]    s3_neg_ff;

   logic          s4_valid_ff;
   logic          s4_vis_ff;
   logic [WB-1:0] s4_w_ff;
   logic [MB-1:0] s4_mag_ff [2];
   logic [1:0]    s4_neg_ff;
   logic [MB-1:0] two_w;

   logic          s5_valid_ff;
   logic [2:0]    s5_tag_ff;
   logic [WB-1:0] s5_w_ff;
   logic [NB-1:0] s5_num_ff [2];

   logic          dv_valid;
   logic [QB-1:0] dv_quot [2];
   logic [2:0]    dv_tag;

   logic          rsp_valid_ff;
   logic          rsp_visible_ff;
   logic [QB-1:0] rsp_x_ff;
   logic [QB-1:0] rsp_y_ff;
   logic [QB-1:0] map_x;
   logic [QB-1:0] map_y;

   // whole pipe moves unless the output word is held
   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;
   assign accept    = req_valid & req_ready;
   assign csr_ready = 1'b1;

   assign half_w = HB'(width_ff >> 1);
   assign half_h = HB'(height_ff >> 1);

   // viewport registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= PIXEL_BITS'(1920);
         height_ff <= PIXEL_BITS'(1080);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pwts_pkg::REG_WIDTH:  width_ff  <= csr_data;
            pwts_pkg::REG_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // matrix coefficients
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pwts_pkg::MAT_DEPTH; i++) mat_ff[i] <= '0;
      end else if (accept && req_operation == pwts_pkg::OP_LOAD) begin
         mat_ff[req_coef_index] <= req_coef_value;
      end
   end

   assign pos[0] = req_pos_x;
   assign pos[1] = req_pos_y;
   assign pos[2] = req_pos_z;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= accept && req_operation == pwts_pkg::OP_PROJECT;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= dv_valid;
      end
   end

   // stage 1: coefficient times coordinate
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < NR; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= $signed(mat_ff[pwts_pkg::ROW_SEL[r]*4 + c]) * pos[c];
            end
            bias_ff[r] <= $signed(mat_ff[pwts_pkg::ROW_SEL[r]*4 + 3]);
         end
      end
   end

   // stage 2: floor each Q32.32 product to Q32.16 and sum with the Q16.16 bias
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < NR; r++) begin
            clip_ff[r] <= LW'($signed(prod_ff[r][0][PW-1:FI]))
                        + LW'($signed(prod_ff[r][1][PW-1:FI]))
                        + LW'($signed(prod_ff[r][2][PW-1:FI]))
                        + LW'(bias_ff[r]);
         end
      end
   end

   // stage 3: visibility, magnitudes and offset direction (y is flipped)
   always_ff @(posedge clock) begin
      if (en) begin
         s3_vis_ff    <= clip_ff[2] >= pwts_pkg::W_MIN;
         s3_w_ff      <= WB'(clip_ff[2]);
         s3_neg_ff[0] <= clip_ff[0][LW-1];
         s3_neg_ff[1] <= ~clip_ff[1][LW-1];
         for (int l = 0; l < 2; l++) begin
            s3_mag_ff[l] <= clip_ff[l][LW-1] ? MB'(-clip_ff[l]) : MB'(clip_ff[l]);
         end
      end
   end

   // stage 4: a ratio beyond two always clamps, so cap the magnitude at 2w
   assign two_w = {s3_w_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         s4_vis_ff <= s3_vis_ff;
         s4_w_ff   <= s3_w_ff;
         s4_neg_ff <= s3_neg_ff;
         for (int l = 0; l < 2; l++) begin
            s4_mag_ff[l] <= (s3_mag_ff[l] > two_w) ? two_w : s3_mag_ff[l];
         end
      end
   end

   // stage 5: dividend = half size * magnitude, in 1/256 pixel
   always_ff @(posedge clock) begin
      if (en) begin
         s5_tag_ff    <= {s4_vis_ff, s4_neg_ff};
         s5_w_ff      <= s4_w_ff;
         s5_num_ff[0] <= {(HB+MB)'(half_w) * s4_mag_ff[0], FB'(0)};
         s5_num_ff[1] <= {(HB+MB)'(half_h) * s4_mag_ff[1], FB'(0)};
      end
   end

   pwts_div #(
      .PIXEL_BITS (PIXEL_BITS),
      .TAG_W      (3)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_valid_ff),
      .in_num    (s5_num_ff),
      .in_den    (s5_w_ff),
      .in_tag    (s5_tag_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_tag   (dv_tag)
   );

   // centre plus or minus offset, clamped to the viewport
   function automatic logic [QB-1:0] place(input logic [QB-1:0] off,
                                           input logic [HB-1:0] half,
                                           input logic [PIXEL_BITS-1:0] size,
                                           input logic neg);
      logic [VB-1:0] centre;
      logic [VB-1:0] offv;
      logic [VB-1:0] lim;
      logic [VB-1:0] v;
      centre = VB'({half, FB'(0)});
      offv   = VB'(off);
      lim    = VB'({size, FB'(0)});
      if (neg) v = (offv > centre) ? '0 : centre - offv;
      else     v = centre + offv;
      if (v > lim) v = lim;
      return QB'(v);
   endfunction

   assign map_x = place(dv_quot[0], half_w, width_ff,  dv_tag[0]);
   assign map_y = place(dv_quot[1], half_h, height_ff, dv_tag[1]);

   // output word
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_visible_ff <= dv_tag[2];
         rsp_x_ff       <= dv_tag[2] ? map_x : '0;
         rsp_y_ff       <= dv_tag[2] ? map_y : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_visible  = rsp_visible_ff;
   assign rsp_screen_x = rsp_x_ff;
   assign rsp_screen_y = rsp_y_ff;

endmodule

`default_nettype wire

// ===== sv/pwts_checker.sv =====
`default_nettype none

module pwts_sva #(
   parameter int PIXEL_BITS = 13
) (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic                      rsp_visible,
   input wire logic [PIXEL_BITS+7:0]     rsp_screen_x,
   input wire logic [PIXEL_BITS+7:0]     rsp_screen_y
);

   // no result word right after reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

   // a point behind the eye lands at the origin
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_screen_x == '0 && rsp_screen_y == '0)
      else $error("hidden point with nonzero coordinates");

   // input is refused only while a result word is held
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   // a held result word keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_x)
                                  && $stable(rsp_screen_y))
      else $error("held result word changed");

endmodule

bind perspective_world_to_screen pwts_sva #(.PIXEL_BITS(PIXEL_BITS)) u_pwts_sva (.*);

`default_nettype wire
